// ----- hdl/dsc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, register codes and helpers for the DMA sound controller.
// No dependencies; imported by dsc_serial, dsc_core, the top level and the testbench.
package dsc_pkg;

  localparam int ADDR_BITS = 24;
  // address registers keep bits 23..1 at most
  localparam int AW_BITS = (ADDR_BITS < 24) ? ADDR_BITS : 24;
  localparam logic [ADDR_BITS-1:0] AW_MASK = ADDR_BITS'((64'd1 << AW_BITS) - 64'd2);

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  // byte register numbers (byte offset >> 1)
  localparam logic [4:0] REG_CTRL     = 5'd0;
  localparam logic [4:0] REG_BEGIN_HI = 5'd1;
  localparam logic [4:0] REG_BEGIN_LO = 5'd3;
  localparam logic [4:0] REG_CUR_HI   = 5'd4;
  localparam logic [4:0] REG_CUR_LO   = 5'd6;
  localparam logic [4:0] REG_END_HI   = 5'd7;
  localparam logic [4:0] REG_END_LO   = 5'd9;
  localparam logic [4:0] REG_MODE     = 5'd16;

  // word offsets of the serial port
  localparam logic [5:0] OFS_SER_DATA = 6'h22;
  localparam logic [5:0] OFS_SER_MASK = 6'h24;

  localparam logic [4:0] SER_STEPS     = 5'd16;
  localparam logic [4:0] SER_CMD_BITS  = 5'd11;
  localparam logic [6:0] VOL_IN_MAX    = 7'd40;
  localparam logic [6:0] VOL_FULL      = 7'd64;
  // v*64/40 = (v*8)/5, and x/5 == (x*205) >> 10 for x <= 320
  localparam logic [7:0] DIV5_RECIP    = 8'd205;
  localparam int         DIV5_SHIFT    = 10;

  typedef struct packed {
    logic       ok;
    logic [6:0] level;
  } dsc_vol_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        dma_done;
    logic        playing;
    logic [23:0] fetch_address;
    logic        stereo_mode;
    logic [6:0]  main_volume;
  } dsc_result_t;

  // byte pos 0 is the high byte of the 24-bit address
  function automatic logic [7:0] get_byte(input logic [31:0] v, input logic [1:0] pos);
    logic [7:0] b;
    case (pos)
      2'd0:    b = v[23:16];
      2'd1:    b = v[15:8];
      default: b = v[7:0];
    endcase
    return b;
  endfunction

  function automatic logic [31:0] put_byte(input logic [31:0] v, input logic [1:0] pos,
                                           input logic [7:0] b);
    logic [31:0] r;
    r = v;
    case (pos)
      2'd0:    r[23:16] = b;
      2'd1:    r[15:8]  = b;
      default: r[7:0]   = b;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/dsc_intf.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the DMA sound controller.
// Standalone; payload widths follow the bus item and result item.
interface dsc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [5:0]  address;
  logic        word_access;
  logic [15:0] write_data;

  modport source (output valid, cmd, address, word_access, write_data, input ready);
  modport sink   (input valid, cmd, address, word_access, write_data, output ready);
endinterface

interface dsc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic        dma_done;
  logic        playing;
  logic [23:0] fetch_address;
  logic        stereo_mode;
  logic [6:0]  main_volume;

  modport source (output valid, read_data, dma_done, playing, fetch_address, stereo_mode,
                  main_volume, input ready);
  modport sink   (input valid, read_data, dma_done, playing, fetch_address, stereo_mode,
                  main_volume, output ready);
endinterface

// ----- hdl/dsc_serial.sv -----
`timescale 1ns / 1ps
// Serial volume decoder: packs data bits under the mask and checks the command.
// Depends on dsc_pkg.
module dsc_serial (
  input  logic [15:0]       data,
  input  logic [15:0]       mask,
  output dsc_pkg::dsc_vol_t vol
);
  import dsc_pkg::*;

  logic [4:0]  pre [16];
  logic [10:0] packed_bits;
  logic [4:0]  used;
  logic [5:0]  v;
  logic [16:0] scaled;

  // packed slot of each mask bit = number of mask bits below it
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      pre[i] = 5'($countones(mask & 16'((17'd1 << i) - 17'd1)));
    end
  end

  always_comb begin
    packed_bits = '0;
    for (int j = 0; j < 11; j++) begin
      for (int i = 0; i < 16; i++) begin
        if (mask[i] && data[i] && (pre[i] == 5'(j))) packed_bits[j] = 1'b1;
      end
    end
  end

  assign used   = 5'($countones(mask));
  assign v      = packed_bits[5:0];
  assign scaled = 17'({v, 3'b000}) * 17'(DIV5_RECIP);

  always_comb begin
    vol.ok = (used == SER_CMD_BITS) && (packed_bits[10:9] == 2'b10)
             && (packed_bits[8:6] == 3'd3);
    if (7'(v) > VOL_IN_MAX) vol.level = VOL_FULL;
    else                    vol.level = 7'(scaled >> DIV5_SHIFT);
  end

endmodule

// ----- hdl/dsc_core.sv -----
`timescale 1ns / 1ps
// Register file, bus decode and playback stepping; one item per go pulse.
// Depends on dsc_pkg and dsc_serial.
module dsc_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  logic [1:0]           cmd,
  input  logic [5:0]           address,
  input  logic                 word_access,
  input  logic [15:0]          write_data,
  output dsc_pkg::dsc_result_t result
);
  import dsc_pkg::*;

  logic [1:0]           ctrl_r, ctrl_nxt;
  logic [ADDR_BITS-1:0] begin_r, begin_nxt;
  logic [ADDR_BITS-1:0] cur_r, cur_nxt;
  logic [ADDR_BITS-1:0] end_r, end_nxt;
  logic                 mono_r, mono_nxt;
  logic [1:0]           rshift_r, rshift_nxt;
  logic [4:0]           rcount_r, rcount_nxt;
  logic [15:0]          sdata_r, sdata_nxt;
  logic [15:0]          smask_r, smask_nxt;
  logic [4:0]           steps_r, steps_nxt;
  logic [6:0]           vol_r, vol_nxt;

  dsc_vol_t             vol_cmd;
  logic [4:0]           regno;
  logic                 byte_ok;
  logic [7:0]           b;
  logic [15:0]          rd;
  logic                 done;
  logic [4:0]           period;
  logic [4:0]           rc_inc;
  logic [ADDR_BITS-1:0] cur_step;

  dsc_serial u_serial (
    .data (write_data),
    .mask (smask_r),
    .vol  (vol_cmd)
  );

  assign regno  = address[5:1];
  assign b      = write_data[7:0];
  // word access at an even offset other than the serial port falls to the odd byte
  assign byte_ok = word_access
                   ? (!address[0] && (address != OFS_SER_DATA) && (address != OFS_SER_MASK))
                   : address[0];
  assign period   = 5'd1 << (3'(rshift_r) + 3'(!mono_r));
  assign rc_inc   = rcount_r + 5'd1;
  assign cur_step = cur_r + (mono_r ? ADDR_BITS'(1) : ADDR_BITS'(2));

  always_comb begin
    ctrl_nxt   = ctrl_r;
    begin_nxt  = begin_r;
    cur_nxt    = cur_r;
    end_nxt    = end_r;
    mono_nxt   = mono_r;
    rshift_nxt = rshift_r;
    rcount_nxt = rcount_r;
    sdata_nxt  = sdata_r;
    smask_nxt  = smask_r;
    steps_nxt  = steps_r;
    vol_nxt    = vol_r;
    rd         = '0;
    done       = 1'b0;

    case (cmd_t'(cmd))
      CMD_READ: begin
        if (word_access && (address == OFS_SER_DATA)) begin
          rd = sdata_r;
        end else if (word_access && (address == OFS_SER_MASK)) begin
          if (steps_r != '0) begin
            steps_nxt = steps_r - 5'd1;
            smask_nxt = {smask_r[14:0], smask_r[15]};
          end
          rd = smask_nxt;
        end else if (byte_ok) begin
          case (regno) inside
            REG_CTRL:                   rd = {14'd0, ctrl_r};
            [REG_BEGIN_HI:REG_BEGIN_LO]:
              rd = {8'd0, get_byte(32'(begin_r), 2'(regno - REG_BEGIN_HI))};
            [REG_CUR_HI:REG_CUR_LO]:
              rd = {8'd0, get_byte(32'(cur_r), 2'(regno - REG_CUR_HI))};
            [REG_END_HI:REG_END_LO]:
              rd = {8'd0, get_byte(32'(end_r), 2'(regno - REG_END_HI))};
            REG_MODE:                   rd = {8'd0, mono_r, 5'd0, ~rshift_r};
            default:                    rd = '0;
          endcase
        end
      end
      CMD_WRITE: begin
        if (word_access && (address == OFS_SER_DATA)) begin
          sdata_nxt = write_data;
          steps_nxt = SER_STEPS;
          if (vol_cmd.ok) vol_nxt = vol_cmd.level;
        end else if (word_access && (address == OFS_SER_MASK)) begin
          smask_nxt = write_data;
        end else if (byte_ok) begin
          case (regno) inside
            REG_CTRL: begin
              if (ctrl_r[0] != b[0]) cur_nxt = begin_r;
              ctrl_nxt = b[1:0];
            end
            [REG_BEGIN_HI:REG_BEGIN_LO]:
              begin_nxt = ADDR_BITS'(put_byte(32'(begin_r), 2'(regno - REG_BEGIN_HI), b))
                          & AW_MASK;
            [REG_CUR_HI:REG_CUR_LO]:
              cur_nxt = ADDR_BITS'(put_byte(32'(cur_r), 2'(regno - REG_CUR_HI), b))
                        & AW_MASK;
            [REG_END_HI:REG_END_LO]:
              end_nxt = ADDR_BITS'(put_byte(32'(end_r), 2'(regno - REG_END_HI), b))
                        & AW_MASK;
            REG_MODE: begin
              mono_nxt   = b[7];
              rshift_nxt = ~b[1:0];
              rcount_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      CMD_TICK: begin
        if (ctrl_r[0]) begin
          if (rc_inc < period) begin
            rcount_nxt = rc_inc;
          end else begin
            rcount_nxt = '0;
            if (cur_step == end_r) begin
              cur_nxt = begin_r;
              if (!ctrl_r[1]) ctrl_nxt[0] = 1'b0;
              done = 1'b1;
            end else begin
              cur_nxt = cur_step;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r   <= '0;
      begin_r  <= '0;
      cur_r    <= '0;
      end_r    <= '0;
      mono_r   <= 1'b0;
      rshift_r <= '0;
      rcount_r <= '0;
      sdata_r  <= '0;
      smask_r  <= '0;
      steps_r  <= '0;
      vol_r    <= '0;
    end else if (go) begin
      ctrl_r   <= ctrl_nxt;
      begin_r  <= begin_nxt;
      cur_r    <= cur_nxt;
      end_r    <= end_nxt;
      mono_r   <= mono_nxt;
      rshift_r <= rshift_nxt;
      rcount_r <= rcount_nxt;
      sdata_r  <= sdata_nxt;
      smask_r  <= smask_nxt;
      steps_r  <= steps_nxt;
      vol_r    <= vol_nxt;
    end
  end

  always_comb begin
    result.read_data     = rd;
    result.dma_done      = done;
    result.playing       = ctrl_nxt[0];
    result.fetch_address = 24'(cur_nxt);
    result.stereo_mode   = !mono_nxt;
    result.main_volume   = vol_nxt;
  end

endmodule

// ----- hdl/dma_sound_controller_with_serial_volume.sv -----
`timescale 1ns / 1ps
// Channel    Dir  Payload                                              Handshake
// in_ch      in   cmd, address, word_access, write_data                valid/ready
// out_ch     out  read_data, dma_done, playing, fetch_address,         valid/ready
//                 stereo_mode, main_volume
//
// Two register stages: an input register, then the register file update and the
// result register in the same cycle. One item per cycle sustained while out_ch is
// not stalled. in_ch.ready drops only when both stages hold an item and out_ch is
// stalled. Synchronous active-low reset clears valid flags and register file; no warm-up.
// Top level; depends on dsc_pkg, dsc_intf, dsc_core, dsc_serial.
module dma_sound_controller_with_serial_volume (
  input  logic      clk,
  input  logic      rst_n,
  dsc_in_if.sink    in_ch,
  dsc_out_if.source out_ch
);
  import dsc_pkg::*;

  logic        s1_valid_r;
  logic [1:0]  s1_cmd_r;
  logic [5:0]  s1_addr_r;
  logic        s1_word_r;
  logic [15:0] s1_wdata_r;
  logic        out_valid_r;
  dsc_result_t out_r;
  dsc_result_t res;
  logic        adv;
  logic        go;

  assign adv          = !out_valid_r || out_ch.ready;
  assign go           = adv && s1_valid_r;
  assign in_ch.ready  = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_cmd_r   <= in_ch.cmd;
      s1_addr_r  <= in_ch.address;
      s1_word_r  <= in_ch.word_access;
      s1_wdata_r <= in_ch.write_data;
    end
  end

  dsc_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (go),
    .cmd         (s1_cmd_r),
    .address     (s1_addr_r),
    .word_access (s1_word_r),
    .write_data  (s1_wdata_r),
    .result      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go) out_r <= res;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.read_data     = out_r.read_data;
  assign out_ch.dma_done      = out_r.dma_done;
  assign out_ch.playing       = out_r.playing;
  assign out_ch.fetch_address = out_r.fetch_address;
  assign out_ch.stereo_mode   = out_r.stereo_mode;
  assign out_ch.main_volume   = out_r.main_volume;

  a_vol_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.main_volume <= VOL_FULL))
    else $error("volume above full scale");

  a_done_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.dma_done) |-> (out_r.read_data == '0))
    else $error("completion flagged on a read item");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled with room in the pipeline");

  a_go_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> out_valid_r)
    else $error("processed item not presented");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the DMA sound controller: a directed table, then random
// register, playback and serial-volume traffic checked against a local predictor.
// Depends on dsc_pkg, dsc_intf and the top-level block.
module testbench;
  import dsc_pkg::*;

  localparam logic [1:0]  CMD_IDLE       = 2'd3;  // fourth command code, does nothing
  localparam logic [5:0]  OFS_UNMAPPED   = 6'h3f;
  localparam logic [23:0] ADDR_EVEN_MASK = 24'hfffffe;
  localparam logic [1:0]  VOL_CMD_PREFIX = 2'b10;
  localparam logic [2:0]  VOL_CMD_ADDR   = 3'd3;
  localparam int RANDOM_ITEMS = 800;
  localparam int CALM_ITEMS   = 120;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_LIMIT  = 2000;
  localparam int SETTLE       = 10;
  localparam int CYCLE_LIMIT  = 300000;

  typedef struct {
    logic [1:0]  cmd;
    logic [5:0]  ofs;
    bit          word;
    logic [15:0] wdata;
    bit          fixed;  // read_data typed in by hand
    logic [15:0] rd;
  } bus_op_t;

  logic clk;
  logic rst_n;
  dsc_in_if  in_ch ();
  dsc_out_if out_ch ();

  dma_sound_controller_with_serial_volume dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predicted register file
  logic [1:0]  ctl_q;
  logic [23:0] loop_begin, play_addr, loop_end;
  bit          mono_q;
  logic [1:0]  shift_q;
  logic [4:0]  tick_cnt;
  logic [15:0] ser_data_q, ser_mask_q;
  logic [4:0]  ser_steps;
  logic [6:0]  vol_q;

  dsc_result_t bus_replies_due[$];
  int  items_sent;
  int  mismatch_count;
  int  src_idle_pct;
  int  sink_stall_pct;
  bit  calm;
  bit  hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] addr_byte(input logic [23:0] a, input int pos);
    return a[8*(2-pos) +: 8];
  endfunction

  function automatic logic [23:0] set_addr_byte(input logic [23:0] a, input int pos,
                                                input logic [7:0] b);
    logic [23:0] t;
    t = a;
    t[8*(2-pos) +: 8] = b;
    return t & ADDR_EVEN_MASK;
  endfunction

  function automatic logic [7:0] reg_read(input logic [5:0] ofs);
    logic [4:0] r;
    r = ofs[5:1];
    if (!ofs[0]) return 8'd0;
    if (r == REG_CTRL) return {6'd0, ctl_q};
    if (r >= REG_BEGIN_HI && r <= REG_BEGIN_LO)
      return addr_byte(loop_begin, int'(r - REG_BEGIN_HI));
    if (r >= REG_CUR_HI && r <= REG_CUR_LO)
      return addr_byte(play_addr, int'(r - REG_CUR_HI));
    if (r >= REG_END_HI && r <= REG_END_LO)
      return addr_byte(loop_end, int'(r - REG_END_HI));
    if (r == REG_MODE) return {mono_q, 5'd0, 2'd3 - shift_q};
    return 8'd0;
  endfunction

  function automatic void reg_write(input logic [5:0] ofs, input logic [7:0] b);
    logic [4:0] r;
    r = ofs[5:1];
    if (!ofs[0]) return;
    if (r == REG_CTRL) begin
      // toggling enable restarts from the loop start
      if (ctl_q[0] != b[0]) play_addr = loop_begin;
      ctl_q = b[1:0];
    end else if (r >= REG_BEGIN_HI && r <= REG_BEGIN_LO) begin
      loop_begin = set_addr_byte(loop_begin, int'(r - REG_BEGIN_HI), b);
    end else if (r >= REG_CUR_HI && r <= REG_CUR_LO) begin
      play_addr = set_addr_byte(play_addr, int'(r - REG_CUR_HI), b);
    end else if (r >= REG_END_HI && r <= REG_END_LO) begin
      loop_end = set_addr_byte(loop_end, int'(r - REG_END_HI), b);
    end else if (r == REG_MODE) begin
      mono_q   = b[7];
      shift_q  = 2'd3 - b[1:0];
      tick_cnt = 5'd0;
    end
  endfunction

  function automatic void serial_write(input logic [15:0] d);
    logic [15:0] gathered;
    int          used;
    int          i;
    int          v;
    ser_data_q = d;
    ser_steps  = SER_STEPS;
    gathered   = 16'd0;
    used       = 0;
    for (i = 0; i < 16; i++) begin
      if (ser_mask_q[i]) begin
        gathered[used] = d[i];
        used++;
      end
    end
    if (used == int'(SER_CMD_BITS) && gathered[10:9] == VOL_CMD_PREFIX &&
        gathered[8:6] == VOL_CMD_ADDR) begin
      v = int'(gathered[5:0]);
      vol_q = (v > int'(VOL_IN_MAX)) ? VOL_FULL : 7'((v * int'(VOL_FULL)) / int'(VOL_IN_MAX));
    end
  endfunction

  function automatic logic [15:0] serial_mask_read();
    if (ser_steps != 5'd0) begin
      ser_steps--;
      ser_mask_q = {ser_mask_q[14:0], ser_mask_q[15]};
    end
    return ser_mask_q;
  endfunction

  function automatic bit advance_playback();
    logic [4:0] period;
    if (!ctl_q[0]) return 1'b0;
    period = 5'd1 << shift_q;
    if (!mono_q) period = period << 1;
    tick_cnt = tick_cnt + 5'd1;
    if (tick_cnt < period) return 1'b0;
    tick_cnt  = 5'd0;
    play_addr = play_addr + (mono_q ? 24'd1 : 24'd2);
    if (play_addr == loop_end) begin
      play_addr = loop_begin;
      if (!ctl_q[1]) ctl_q[0] = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic dsc_result_t apply_bus_item(input bus_op_t op);
    dsc_result_t res;
    res = '0;
    case (op.cmd)
      CMD_READ: begin
        if (!op.word) res.read_data = {8'd0, reg_read(op.ofs)};
        else if (!op.ofs[0]) begin
          if (op.ofs == OFS_SER_DATA) res.read_data = ser_data_q;
          else if (op.ofs == OFS_SER_MASK) res.read_data = serial_mask_read();
          else res.read_data = {8'd0, reg_read(op.ofs + 6'd1)};
        end
      end
      CMD_WRITE: begin
        if (!op.word) reg_write(op.ofs, op.wdata[7:0]);
        else if (!op.ofs[0]) begin
          if (op.ofs == OFS_SER_DATA) serial_write(op.wdata);
          else if (op.ofs == OFS_SER_MASK) ser_mask_q = op.wdata;
          else reg_write(op.ofs + 6'd1, op.wdata[7:0]);
        end
      end
      CMD_TICK: res.dma_done = advance_playback();
      default: ;
    endcase
    res.playing       = ctl_q[0];
    res.fetch_address = play_addr;
    res.stereo_mode   = !mono_q;
    res.main_volume   = vol_q;
    return res;
  endfunction

  function automatic bus_op_t mk(input logic [1:0] cmd, input logic [5:0] ofs, input bit word,
                                 input logic [15:0] wdata);
    bus_op_t op;
    op.cmd   = cmd;
    op.ofs   = ofs;
    op.word  = word;
    op.wdata = wdata;
    op.fixed = 1'b0;
    op.rd    = 16'd0;
    return op;
  endfunction

  function automatic bus_op_t rd_row(input logic [1:0] cmd, input logic [5:0] ofs,
                                     input bit word, input logic [15:0] rd);
    bus_op_t op;
    op = mk(cmd, ofs, word, 16'hffff);
    op.fixed = 1'b1;
    op.rd    = rd;
    return op;
  endfunction

  function automatic logic [5:0] bofs(input logic [4:0] r);
    return {r, 1'b1};
  endfunction

  task automatic flag_mismatch(input string what, input logic [23:0] want_v,
                               input logic [23:0] got_v);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %s: expected %0h, got %0h", what, want_v, got_v);
  endtask

  // called right after a rising edge; returns at the edge where the item is taken
  task automatic issue(input bus_op_t op);
    dsc_result_t reply;
    if (!calm && $urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= op.cmd;
    in_ch.address     <= op.ofs;
    in_ch.word_access <= op.word;
    in_ch.write_data  <= op.wdata;
    do @(posedge clk); while (!in_ch.ready);
    reply = apply_bus_item(op);
    if (op.fixed) reply.read_data = op.rd;
    bus_replies_due.push_back(reply);
    items_sent++;
  endtask

  // byte register write, sometimes as a word access at the even offset below
  task automatic put_reg(input logic [4:0] r, input logic [7:0] b);
    bit word;
    word = 1'($urandom_range(0, 1));
    issue(mk(CMD_WRITE, {r, ~word}, word, {8'($urandom), b}));
  endtask

  task automatic set_addr24(input logic [4:0] r_hi, input logic [23:0] a);
    int k;
    for (k = 0; k < 3; k++) put_reg(r_hi + 5'(k), a[8*(2-k) +: 8]);
  endtask

  task automatic peek_reg();
    int         idx;
    logic [4:0] r;
    bit         word;
    idx  = $urandom_range(0, 10);
    r    = (idx == 10) ? REG_MODE : 5'(idx);
    word = 1'($urandom_range(0, 1));
    issue(mk(CMD_READ, {r, ~word}, word, 16'($urandom)));
  endtask

  task automatic run_playback();
    logic [23:0] start_a, stop_a;
    bit          mono, loop_en;
    logic [1:0]  code;
    int          period, k, ticks, i;
    mono    = 1'($urandom_range(0, 1));
    code    = 2'($urandom_range(0, 3));
    loop_en = 1'($urandom_range(0, 1));
    start_a = ($urandom_range(0, 3) == 0) ? {16'hffff, 8'($urandom)} : 24'($urandom);
    start_a = start_a & ADDR_EVEN_MASK;
    period  = (1 << (3 - code)) * (mono ? 1 : 2);
    k       = $urandom_range(1, (period >= 8) ? 2 : 5);
    stop_a  = start_a + 24'(k * (mono ? 1 : 2));
    if ($urandom_range(0, 7) == 0) stop_a = 24'($urandom);  // usually never reached
    put_reg(REG_CTRL, {6'($urandom), loop_en, 1'b0});
    set_addr24(REG_BEGIN_HI, start_a);
    set_addr24(REG_END_HI, stop_a);
    put_reg(REG_MODE, {mono, 5'($urandom), code});
    if ($urandom_range(0, 5) == 0) set_addr24(REG_CUR_HI, 24'($urandom));
    put_reg(REG_CTRL, {6'($urandom), loop_en, 1'b1});
    ticks = period * k * (loop_en ? 2 : 1) + $urandom_range(0, 4);
    if (ticks > 80) ticks = 80;
    for (i = 0; i < ticks; i++) begin
      if ($urandom_range(0, 4) == 0) peek_reg();
      else issue(mk(CMD_TICK, 6'($urandom), 1'($urandom_range(0, 1)), 16'($urandom)));
    end
  endtask

  task automatic run_volume();
    logic [15:0] sel_mask, sdata;
    logic [10:0] cmd_bits;
    logic [5:0]  v;
    int          j, used, cleared, reads;
    if ($urandom_range(0, 9) < 7) begin
      sel_mask = 16'hffff;
      cleared  = 0;
      while (cleared < 5) begin
        j = $urandom_range(0, 15);
        if (sel_mask[j]) begin
          sel_mask[j] = 1'b0;
          cleared++;
        end
      end
    end else begin
      sel_mask = 16'($urandom);
    end
    case ($urandom_range(0, 3))
      0:       v = 6'd40;
      1:       v = 6'd41;
      default: v = 6'($urandom);
    endcase
    cmd_bits = ($urandom_range(0, 4) != 0) ? {VOL_CMD_PREFIX, VOL_CMD_ADDR, v}
                                           : 11'($urandom);
    sdata = 16'($urandom);
    used  = 0;
    for (j = 0; j < 16; j++) begin
      if (sel_mask[j]) begin
        if (used < 11) sdata[j] = cmd_bits[used];
        used++;
      end
    end
    issue(mk(CMD_WRITE, OFS_SER_MASK, 1'b1, sel_mask));
    issue(mk(CMD_WRITE, OFS_SER_DATA, 1'b1, sdata));
    // sometimes read past the end of the rotation window
    reads = ($urandom_range(0, 3) == 0) ? 18 : $urandom_range(0, 4);
    for (j = 0; j < reads; j++)
      issue(mk(CMD_READ, ($urandom_range(0, 3) == 0) ? OFS_SER_DATA : OFS_SER_MASK, 1'b1,
               16'($urandom)));
  endtask

  task automatic run_noise();
    int n, i;
    n = $urandom_range(3, 12);
    for (i = 0; i < n; i++)
      issue(mk(2'($urandom_range(0, 3)), 6'($urandom), 1'($urandom_range(0, 1)),
               16'($urandom)));
  endtask

  task automatic wait_all_replies();
    in_ch.valid <= 1'b0;
    while (bus_replies_due.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin : sink_ctl
    int hold_cnt;
    bit held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req && !held) begin
        out_ch.ready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge clk);
        held = 1'b1;
      end else if (!calm && $urandom_range(0, 99) < sink_stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    dsc_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (bus_replies_due.size() == 0) begin
        flag_mismatch("result with nothing predicted", 24'd0, 24'(out_ch.read_data));
      end else begin
        want = bus_replies_due.pop_front();
        if (out_ch.read_data !== want.read_data)
          flag_mismatch("read_data", 24'(want.read_data), 24'(out_ch.read_data));
        if (out_ch.dma_done !== want.dma_done)
          flag_mismatch("dma_done", 24'(want.dma_done), 24'(out_ch.dma_done));
        if (out_ch.playing !== want.playing)
          flag_mismatch("playing", 24'(want.playing), 24'(out_ch.playing));
        if (out_ch.fetch_address !== want.fetch_address)
          flag_mismatch("fetch_address", want.fetch_address, out_ch.fetch_address);
        if (out_ch.stereo_mode !== want.stereo_mode)
          flag_mismatch("stereo_mode", 24'(want.stereo_mode), 24'(out_ch.stereo_mode));
        if (out_ch.main_volume !== want.main_volume)
          flag_mismatch("main_volume", 24'(want.main_volume), 24'(out_ch.main_volume));
      end
    end
  end

  initial begin : watchdog
    int unsigned cycle_count;
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    bus_op_t directed[$];
    int      total, sel, n;
    bit      hold_done, pause_done;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.cmd         <= CMD_READ;
    in_ch.address     <= 6'd0;
    in_ch.word_access <= 1'b0;
    in_ch.write_data  <= 16'd0;
    ctl_q = '0; loop_begin = '0; play_addr = '0; loop_end = '0;
    mono_q = 1'b0; shift_q = '0; tick_cnt = '0;
    ser_data_q = '0; ser_mask_q = '0; ser_steps = '0; vol_q = '0;
    items_sent = 0; mismatch_count = 0;
    src_idle_pct = 20; sink_stall_pct = 20;
    calm = 1'b0; hold_req = 1'b0; hold_done = 1'b0; pause_done = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // state after reset, a short mono playback to the end address, volume commands
    // at and below the clip edge, rotation of the mask, and the ignored access shapes
    directed.push_back(rd_row(CMD_READ, bofs(REG_CTRL), 1'b0, 16'h0000));
    directed.push_back(rd_row(CMD_READ, bofs(REG_MODE), 1'b0, 16'h0003));
    directed.push_back(mk(CMD_WRITE, bofs(REG_BEGIN_HI), 1'b0, 16'hab12));
    directed.push_back(mk(CMD_WRITE, bofs(REG_BEGIN_HI + 5'd1), 1'b0, 16'h0034));
    directed.push_back(mk(CMD_WRITE, bofs(REG_BEGIN_LO), 1'b0, 16'h00ff));
    directed.push_back(rd_row(CMD_READ, bofs(REG_BEGIN_LO), 1'b0, 16'h00fe));
    directed.push_back(mk(CMD_WRITE, bofs(REG_END_HI), 1'b0, 16'h0012));
    directed.push_back(mk(CMD_WRITE, bofs(REG_END_HI + 5'd1), 1'b0, 16'h0035));
    directed.push_back(mk(CMD_WRITE, bofs(REG_END_LO), 1'b0, 16'h0001));
    directed.push_back(mk(CMD_WRITE, bofs(REG_MODE), 1'b0, 16'h0083));
    directed.push_back(mk(CMD_WRITE, bofs(REG_CTRL), 1'b0, 16'h0001));
    directed.push_back(rd_row(CMD_READ, bofs(REG_CUR_LO), 1'b0, 16'h00fe));
    directed.push_back(mk(CMD_TICK, 6'd0, 1'b0, 16'h0000));
    directed.push_back(mk(CMD_TICK, 6'h3f, 1'b1, 16'hffff));
    directed.push_back(rd_row(CMD_READ, bofs(REG_CTRL), 1'b0, 16'h0000));
    directed.push_back(mk(CMD_WRITE, OFS_SER_MASK, 1'b1, 16'h07ff));
    directed.push_back(mk(CMD_WRITE, OFS_SER_DATA, 1'b1, 16'h04e8));
    directed.push_back(mk(CMD_WRITE, OFS_SER_DATA, 1'b1, 16'h04d9));
    directed.push_back(rd_row(CMD_READ, OFS_SER_MASK, 1'b1, 16'h0ffe));
    directed.push_back(rd_row(CMD_READ, OFS_SER_DATA, 1'b1, 16'h04d9));
    directed.push_back(rd_row(CMD_READ, bofs(REG_MODE), 1'b1, 16'h0000));
    directed.push_back(rd_row(CMD_READ, {REG_MODE, 1'b0}, 1'b0, 16'h0000));
    directed.push_back(rd_row(CMD_READ, OFS_UNMAPPED, 1'b0, 16'h0000));
    directed.push_back(rd_row(CMD_IDLE, bofs(REG_CTRL), 1'b1, 16'h0000));
    directed.push_back(mk(CMD_WRITE, {REG_CUR_HI, 1'b0}, 1'b1, 16'hffff));
    directed.push_back(rd_row(CMD_READ, {REG_CUR_HI, 1'b0}, 1'b1, 16'h00ff));
    foreach (directed[i]) issue(directed[i]);

    total = items_sent + RANDOM_ITEMS;
    while (items_sent < total) begin
      case ($urandom_range(0, 2))
        0:       src_idle_pct = 0;
        1:       src_idle_pct = 15;
        default: src_idle_pct = 40;
      endcase
      case ($urandom_range(0, 2))
        0:       sink_stall_pct = 0;
        1:       sink_stall_pct = 10;
        default: sink_stall_pct = 40;
      endcase
      if (items_sent >= total - CALM_ITEMS) calm = 1'b1;
      if (!hold_done && items_sent >= total - 600) begin
        hold_req  = 1'b1;  // sender keeps going, the block backs up
        hold_done = 1'b1;
      end
      if (!pause_done && items_sent >= total - 350) begin
        wait_all_replies();
        pause_done = 1'b1;
      end
      sel = $urandom_range(0, 9);
      if (sel < 5) run_playback();
      else if (sel < 7) run_volume();
      else run_noise();
    end
    in_ch.valid <= 1'b0;

    for (n = 0; n < DRAIN_LIMIT && bus_replies_due.size() != 0; n++) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (bus_replies_due.size() != 0)
      flag_mismatch("outstanding result count", 24'd0, 24'(bus_replies_due.size()));
    if (mismatch_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
